// ===== hdl/idxarr_pkg.sv =====
package idxarr_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LOWER,
    CELL_FROM_UPPER
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     live;
  } cell_ctrl_t;

endpackage

// ===== hdl/idxarr_req_if.sv =====
interface idxarr_req_if;
  import idxarr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, action, position, item_value, input ready);
  modport sink (input valid, action, position, item_value, output ready);
endinterface

// ===== hdl/idxarr_rsp_if.sv =====
interface idxarr_rsp_if;
  import idxarr_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             found;
  logic [IDX_W-1:0] found_position;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, status, found, found_position, entry_count, input ready);
  modport sink (input valid, status, found, found_position, entry_count, output ready);
endinterface

// ===== hdl/indexed_insert_delete_search_array_top.sv =====
// A transaction is answered in the cycle after it is accepted.
// Throughput: one transaction per cycle unless rsp.ready stalls; every
// cell shifts or compares in parallel; a registered response stage decouples
// the two sides. Reset: rst (synchronous, active high) empties the list
// and drops any pending response; cell contents are not cleared.
module indexed_insert_delete_search_array_top (
  input logic          clk,
  input logic          rst,
  idxarr_req_if.sink   req,
  idxarr_rsp_if.source rsp
);
  import idxarr_pkg::*;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              fire;
  action_t           action;
  logic [POS_W-1:0]  pos;
  status_t           status_next;
  logic              write_ok;
  logic              found_next;
  logic [IDX_W-1:0]  found_pos_next;
  cell_ctrl_t        ctrl [DEPTH];
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  match;

  assign req.ready = !rsp.valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign action    = action_t'(req.action);
  assign pos       = req.position;

  always_comb begin
    status_next = ST_DONE;
    write_ok    = 1'b0;
    count_next  = count;
    unique case (action)
      ACT_INSERT: begin
        if (POS_W'(pos) > POS_W'(count)) begin
          status_next = ST_RANGE;
        end else if (count >= CNT_W'(DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          write_ok   = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      ACT_DELETE: begin
        if (POS_W'(pos) >= POS_W'(count)) begin
          status_next = ST_RANGE;
        end else begin
          write_ok   = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] upper;

    always_comb begin
      ctrl[i].live = (CNT_W'(i) < count);
      ctrl[i].op   = CELL_HOLD;
      if (fire && write_ok) begin
        if (action == ACT_INSERT) begin
          if (POS_W'(i) == pos) begin
            ctrl[i].op = CELL_LOAD;
          end else if (POS_W'(i) > pos) begin
            ctrl[i].op = CELL_FROM_LOWER;
          end
        end else if (POS_W'(i) >= pos) begin
          ctrl[i].op = CELL_FROM_UPPER;
        end
      end
    end

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end

    idxarr_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .key        (req.item_value),
      .lower_data (lower),
      .upper_data (upper),
      .data       (cell_data[i]),
      .match      (match[i])
    );
  end

  always_comb begin
    found_next     = 1'b0;
    found_pos_next = '0;
    if (action == ACT_SEARCH) begin
      for (int i = DEPTH - 1; i >= 0; i--) begin
        if (match[i]) begin
          found_next     = 1'b1;
          found_pos_next = IDX_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (fire) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.status         <= status_next;
      rsp.found          <= found_next;
      rsp.found_position <= found_pos_next;
      rsp.entry_count    <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    fire && action == ACT_INSERT && status_next == ST_DONE |=>
      count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_found_in_list: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> CNT_W'(rsp.found_position) < rsp.entry_count)
    else $error("found position outside the list");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_FULL |-> rsp.entry_count == CNT_W'(DEPTH))
    else $error("full status while list not full");

endmodule

// ===== hdl/idxarr_cell.sv =====
module idxarr_cell (
  input  logic                            clk,
  input  idxarr_pkg::cell_ctrl_t          ctrl,
  input  logic [idxarr_pkg::DATA_W-1:0]   key,
  input  logic [idxarr_pkg::DATA_W-1:0]   lower_data,
  input  logic [idxarr_pkg::DATA_W-1:0]   upper_data,
  output logic [idxarr_pkg::DATA_W-1:0]   data,
  output logic                            match
);
  import idxarr_pkg::*;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_LOAD:       data <= key;
      CELL_FROM_LOWER: data <= lower_data;
      CELL_FROM_UPPER: data <= upper_data;
      default:         data <= data;
    endcase
  end

  assign match = ctrl.live && (data == key);
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import idxarr_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    status_t          status;
    logic             found;
    logic [IDX_W-1:0] found_position;
    logic [CNT_W-1:0] entry_count;
  } answer_t;

  class list_mirror;
    logic signed [DATA_W-1:0] cells [DEPTH];
    int                       count;
    answer_t                  answers_due [$];
    int                       errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void apply_op(action_t act, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] value);
      answer_t ans;
      int      p;
      p = int'(pos);
      ans = '{status: ST_DONE, found: 1'b0, found_position: '0, entry_count: '0};
      case (act)
        ACT_INSERT: begin
          if (p > count) begin
            ans.status = ST_RANGE;
          end else if (count >= DEPTH) begin
            ans.status = ST_FULL;
          end else begin
            for (int i = count; i > p; i--) cells[i] = cells[i-1];
            cells[p] = value;
            count++;
          end
        end
        ACT_DELETE: begin
          if (p >= count) begin
            ans.status = ST_RANGE;
          end else begin
            for (int i = p; i + 1 < count; i++) cells[i] = cells[i+1];
            count--;
          end
        end
        ACT_SEARCH: begin
          for (int i = 0; i < count; i++) begin
            if (!ans.found && cells[i] == value) begin
              ans.found = 1'b1;
              ans.found_position = IDX_W'(i);
            end
          end
        end
        default: ;
      endcase
      ans.entry_count = CNT_W'(count);
      answers_due.push_back(ans);
    endfunction

    task check_answer(logic [1:0] status, logic found,
                      logic [IDX_W-1:0] fpos, logic [CNT_W-1:0] cnt);
      answer_t exp;
      if (answers_due.size() == 0) begin
        report_mismatch("response with no transaction pending");
        return;
      end
      exp = answers_due.pop_front();
      if (status !== exp.status)
        report_mismatch($sformatf("status %0d, want %0d", status, exp.status));
      if (found !== exp.found)
        report_mismatch($sformatf("found %0b, want %0b", found, exp.found));
      if (fpos !== exp.found_position)
        report_mismatch($sformatf("found_position %0d, want %0d", fpos,
                                  exp.found_position));
      if (cnt !== exp.entry_count)
        report_mismatch($sformatf("entry_count %0d, want %0d", cnt, exp.entry_count));
    endtask
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   burst_left;

  idxarr_req_if req_if ();
  idxarr_rsp_if rsp_if ();

  list_mirror mirror = new();

  indexed_insert_delete_search_array_top dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[indexed_insert_delete_search_array_top] ERROR");
      $finish;
    end
  end

  // check the response before noting a new request at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready)
        mirror.check_answer(rsp_if.status, rsp_if.found, rsp_if.found_position,
                            rsp_if.entry_count);
      if (req_if.valid && req_if.ready)
        mirror.apply_op(action_t'(req_if.action), req_if.position, req_if.item_value);
    end
  end

  initial begin
    int mode;
    int tick;
    mode = 0;
    tick = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (tick % 64 == 0) mode = $urandom_range(0, 4);
      case (mode)
        0: rsp_if.ready = 1'b1;
        1: rsp_if.ready = $urandom_range(0, 1);
        2: rsp_if.ready = (tick % 4 != 3);
        3: rsp_if.ready = (tick % 16 < 4);
        default: rsp_if.ready = ($urandom_range(0, 7) != 0);
      endcase
      tick++;
    end
  end

  task automatic send_op(action_t act, int pos, logic signed [DATA_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    req_if.action = act;
    req_if.position = POS_W'(pos);
    req_if.item_value = value;
    req_if.valid = 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4:    return $urandom_range(0, 6) - 3;
      5:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return (mirror.count > 0) ? mirror.cells[$urandom_range(0, mirror.count - 1)]
                                         : $urandom;
    endcase
  endfunction

  initial begin
    int ins_pct [6];
    int del_pct [6];
    int r;
    int pos;
    ins_pct = '{50, 70, 20, 80, 30, 45};
    del_pct = '{30, 10, 60, 10, 50, 35};
    burst_left = 0;
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.action = ACT_NONE;
    req_if.position = '0;
    req_if.item_value = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    send_op(ACT_SEARCH, 0, 0);
    send_op(ACT_DELETE, 0, 0);
    send_op(ACT_INSERT, 1, 5);
    send_op(ACT_INSERT, 31, -1);
    send_op(ACT_INSERT, 0, 32'sh7FFF_FFFF);
    send_op(ACT_INSERT, 1, 32'sh8000_0000);
    send_op(ACT_INSERT, 0, 0);
    send_op(ACT_INSERT, 2, -1);
    send_op(ACT_INSERT, 4, -1);
    send_op(ACT_SEARCH, 0, -1);
    send_op(ACT_SEARCH, 31, 32'sh8000_0000);
    send_op(ACT_SEARCH, 7, 32'sh7FFF_FFFF);
    send_op(ACT_SEARCH, 0, 12345);
    send_op(ACT_NONE, 31, -1);
    send_op(ACT_DELETE, 5, 0);
    send_op(ACT_DELETE, 4, 0);
    send_op(ACT_DELETE, 0, 0);
    send_op(ACT_SEARCH, 0, 0);
    send_op(ACT_DELETE, 31, 32'sh5A5A_A5A5);

    for (int ph = 0; ph < 6; ph++) begin
      for (int n = 0; n < 225; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_op(ACT_NONE, $urandom_range(0, 31), $urandom);
        end else if (r < 3 + ins_pct[ph]) begin
          pos = ($urandom_range(0, 99) < 85) ? $urandom_range(0, mirror.count)
                                             : $urandom_range(0, 31);
          send_op(ACT_INSERT, pos, pick_value());
        end else if (r < 3 + ins_pct[ph] + del_pct[ph]) begin
          if ($urandom_range(0, 99) < 85 && mirror.count > 0)
            pos = $urandom_range(0, mirror.count - 1);
          else
            pos = $urandom_range(0, 31);
          send_op(ACT_DELETE, pos, $urandom);
        end else begin
          send_op(ACT_SEARCH, $urandom_range(0, 31), pick_value());
        end
      end
    end

    req_if.valid = 1'b0;
    while (mirror.answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mirror.answers_due.size() != 0)
      mirror.report_mismatch($sformatf("%0d responses never arrived",
                                       mirror.answers_due.size()));
    if (mirror.errors == 0)
      $display("[indexed_insert_delete_search_array_top] OK");
    else
      $display("[indexed_insert_delete_search_array_top] ERROR");
    $finish;
  end

endmodule
